@@ hw/rtl/lts_pkg.sv @@
// Package for the LIS length stream block: field widths and default depth.
// Used by the channel interfaces, the tail cell and the top level.
package lts_pkg;

  // Field widths fixed by the word formats
  localparam int VALUE_W = 32;
  localparam int LEN_W   = 9;

  // Default number of tail cells
  localparam int MAX_TAILS_DEF = 256;

  // Per-cell status handed to the top level
  typedef struct packed {
    logic hit;     // cell is free or its tail is >= the incoming value
    logic append;  // value lands in the first free cell
  } cell_status_t;

endpackage

@@ hw/rtl/lts_in_if.sv @@
// Input channel: one sequence element per word, valid/ready handshake.
// Depends on lts_pkg for the field width.
interface lts_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [lts_pkg::VALUE_W-1:0] value;
  logic                               last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

@@ hw/rtl/lts_out_if.sv @@
// Output channel: one result word per sequence, valid/ready handshake.
// Depends on lts_pkg for the field width.
interface lts_out_if;
  logic                           valid;
  logic                           ready;
  logic [lts_pkg::LEN_W-1:0]      lis_length;
  logic                           overflow;

  modport source (output valid, output lis_length, output overflow, input ready);
  modport sink   (input valid, input lis_length, input overflow, output ready);
endinterface

@@ hw/rtl/lts_cell.sv @@
// One tail cell of the patience chain: holds one tail and compares it.
// Depends on lts_pkg for widths and the status struct.
module lts_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 9
) (
  input  logic                               clk,
  input  logic                               take_en,
  input  logic signed [lts_pkg::VALUE_W-1:0] value,
  input  logic [CNT_W-1:0]                   count,
  input  logic                               prev_hit,
  output lts_pkg::cell_status_t              status
);
  import lts_pkg::*;

  logic signed [VALUE_W-1:0] tail;
  logic                      occupied;
  logic                      hit;
  logic                      first_hit;

  // Compare against the held tail; a free cell always hits
  assign occupied  = CNT_W'(INDEX) < count;
  assign hit       = !occupied || (tail >= value);
  assign first_hit = hit && !prev_hit;

  assign status.hit    = hit;
  assign status.append = first_hit && !occupied;

  // Replace or fill the tail when this is the first hitting cell
  always_ff @(posedge clk) begin
    if (take_en && first_hit) begin
      tail <= value;
    end
  end

endmodule

@@ hw/rtl/lis_length_tails_stream.sv @@
// Streaming LIS length over signed 32-bit words (patience tails in a cell chain).
// Takes one word per cycle unless stalled; the result word appears in the cycle after
// the word marked last is accepted, held in an output register until taken.
// Input stalls only while a result waits and the output side is not ready.
// Reset clears the tail count, the overflow flag and the result valid flag;
// the tail cells are not cleared (a cell at or above the count is treated as free).
module lis_length_tails_stream #(
  parameter int MAX_TAILS = lts_pkg::MAX_TAILS_DEF
) (
  input logic       clk,
  input logic       rst,
  lts_in_if.sink    items,
  lts_out_if.source results
);
  import lts_pkg::*;

  localparam int CNT_W = $clog2(MAX_TAILS + 1);

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               overflow_seen;
  logic               overflow_next;
  logic               accept;
  logic               appended;
  logic               dropped;
  logic [MAX_TAILS-1:0] hits;
  logic [MAX_TAILS-1:0] appends;
  cell_status_t       status [MAX_TAILS];

  assign items.ready = !results.valid || results.ready;
  assign accept      = items.valid && items.ready;

  // Build the chain; each cell sees its left neighbor's hit
  for (genvar i = 0; i < MAX_TAILS; i++) begin : g_cell
    logic prev_hit;
    if (i == 0) begin : g_first
      assign prev_hit = 1'b0;
    end else begin : g_rest
      assign prev_hit = hits[i-1];
    end

    lts_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .take_en  (accept),
      .value    (items.value),
      .count    (count),
      .prev_hit (prev_hit),
      .status   (status[i])
    );

    assign hits[i]    = status[i].hit;
    assign appends[i] = status[i].append;
  end

  // No hit at the last cell means the store is full and the value is larger
  assign appended      = |appends;
  assign dropped       = !hits[MAX_TAILS-1];
  assign count_next    = appended ? count + CNT_W'(1) : count;
  assign overflow_next = overflow_seen || dropped;

  // Advance count and flag; emit and clear on the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      overflow_seen <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      if (accept) begin
        if (items.last_item) begin
          count              <= '0;
          overflow_seen      <= 1'b0;
          results.valid      <= 1'b1;
          results.lis_length <= LEN_W'(count_next);
          results.overflow   <= overflow_next;
        end else begin
          count         <= count_next;
          overflow_seen <= overflow_next;
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_lis_length_tails_stream.sv @@
// Self-checking testbench for lis_length_tails_stream: streams sequences of words,
// predicts each LIS length and overflow flag, and checks every result word.
// Depends on lts_pkg, lts_in_if and lts_out_if.
`timescale 1ns / 1ps

module tb_lis_length_tails_stream;
  import lts_pkg::*;

  localparam int MAX_TAILS   = MAX_TAILS_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int WORD_TARGET = 475;
  localparam int DRAIN_LIMIT = 5000;

  typedef struct {
    logic [LEN_W-1:0] lis_length;
    logic             overflow;
  } lis_result_t;

  // Patience-tail predictor plus the queue of result words still owed
  class lis_tracker;
    logic signed [VALUE_W-1:0] tails[];
    int                        tail_cnt;
    bit                        ovf_seen;
    int                        depth;
    lis_result_t               owed[$];
    int                        errors;

    function new(int max_tails);
      depth    = max_tails;
      tails    = new[max_tails];
      tail_cnt = 0;
      ovf_seen = 0;
      errors   = 0;
    endfunction

    // Fold one accepted word into the tails; owe a result on the last word
    function void note_input(logic signed [VALUE_W-1:0] v, logic last);
      lis_result_t r;
      bit          placed;
      if (tail_cnt == 0 || v > tails[tail_cnt-1]) begin
        if (tail_cnt < depth) begin
          tails[tail_cnt] = v;
          tail_cnt++;
        end else begin
          ovf_seen = 1'b1;
        end
      end else begin
        placed = 1'b0;
        for (int i = 0; i < tail_cnt && !placed; i++) begin
          if (tails[i] >= v) begin
            tails[i] = v;
            placed   = 1'b1;
          end
        end
      end
      if (last) begin
        r.lis_length = tail_cnt[LEN_W-1:0];
        r.overflow   = ovf_seen;
        owed.push_back(r);
        tail_cnt = 0;
        ovf_seen = 1'b0;
      end
    endfunction

    // Compare one taken result word against the oldest owed one
    function void check_result(logic [LEN_W-1:0] len, logic ovf);
      lis_result_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result word: lis_length %0d overflow %0b",
                 $time, len, ovf);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (len !== want.lis_length) begin
        $display("%0t: lis_length mismatch: expected %0d actual %0d",
                 $time, want.lis_length, len);
        errors++;
      end
      if (ovf !== want.overflow) begin
        $display("%0t: overflow mismatch: expected %0b actual %0b",
                 $time, want.overflow, ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  lts_in_if  items_if();
  lts_out_if results_if();

  lis_length_tails_stream #(.MAX_TAILS(MAX_TAILS)) uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  lis_tracker tracker = new(MAX_TAILS);
  bit         no_idle     = 1'b0;
  bit         hold_output = 1'b0;
  int         word_count  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mostly short gaps, a few long ones, none in a quiet stretch
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mix extremes, a narrow band that forces ties, and full-range words
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7FFF_FFFF;
          2:       return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3, 4: return $urandom_range(0, 16) - 8;
      default:    return $urandom;
    endcase
  endfunction

  // Offer one word after a gap and return at the edge that takes it
  task automatic send_word(input logic signed [VALUE_W-1:0] v, input logic last,
                           input int gap);
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_if.valid     <= 1'b1;
    items_if.value     <= v;
    items_if.last_item <= last;
    do @(negedge clk); while (!items_if.ready);
    @(posedge clk);
    tracker.note_input(v, last);
    word_count++;
  endtask

  // Sample the result handshake mid-cycle, away from the driving edge
  always @(negedge clk) begin
    if (!rst && results_if.valid && results_if.ready)
      tracker.check_result(results_if.lis_length, results_if.overflow);
  end

  // Result side: random stalls plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    results_if.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_output) begin
        results_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end
      if (stall_left > 0 && !no_idle) begin
        results_if.ready <= 1'b0;
        stall_left--;
      end else begin
        results_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    longint base;
    int     appends;
    int     seq_idx;
    int     len;
    int     full_run_at;
    int     waited;

    rst                <= 1'b1;
    items_if.valid     <= 1'b0;
    items_if.value     <= '0;
    items_if.last_item <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // One-word sequences at zero and both extremes
    send_word(32'sd0, 1'b1, pick_gap());
    send_word(32'sh8000_0000, 1'b1, pick_gap());
    send_word(32'sh7FFF_FFFF, 1'b1, pick_gap());
    // Extremes, then a replacement in the middle
    send_word(32'sh8000_0000, 1'b0, pick_gap());
    send_word(32'sh7FFF_FFFF, 1'b0, pick_gap());
    send_word(32'sd0, 1'b0, pick_gap());
    send_word(32'sd5, 1'b1, pick_gap());
    // Equal words do not extend a strictly increasing run
    send_word(32'sd7, 1'b0, pick_gap());
    send_word(32'sd7, 1'b0, pick_gap());
    send_word(32'sd7, 1'b1, pick_gap());
    // Strictly decreasing, crossing zero
    for (int k = 3; k >= -1; k--) send_word(k, k == -1, pick_gap());
    // Strictly increasing
    for (int k = 1; k <= 4; k++) send_word(k, k == 4, pick_gap());
    // Replace an inner tail, then extend past it
    send_word(32'sd1, 1'b0, pick_gap());
    send_word(32'sd5, 1'b0, pick_gap());
    send_word(32'sd3, 1'b0, pick_gap());
    send_word(32'sd4, 1'b1, pick_gap());

    // Random sequences; block the result side first so the input backs up
    hold_output = 1'b1;
    full_run_at = $urandom_range(3, 15);
    seq_idx     = 0;
    while (word_count < WORD_TARGET) begin
      no_idle = (seq_idx >= 18 && seq_idx < 25);
      if (seq_idx == full_run_at) begin
        // Overrun the tail store, with some replacements mixed in
        base    = -64'sd2_000_000_000;
        appends = 0;
        while (appends < MAX_TAILS + 6) begin
          if ($urandom_range(0, 9) == 0) begin
            send_word(32'(base - $urandom_range(0, 2000)), 1'b0, pick_gap());
          end else begin
            base = base + $urandom_range(1, 5_000_000);
            appends++;
            send_word(32'(base), 1'b0, pick_gap());
          end
        end
        send_word(pick_value(), 1'b1, pick_gap());
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) send_word(pick_value(), k == len - 1, pick_gap());
      end
      seq_idx++;
    end
    no_idle = 1'b0;
    items_if.valid <= 1'b0;

    // Drain owed results, then allow for the output register latency
    waited = 0;
    while (tracker.owed.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (tracker.owed.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, tracker.owed.size());
      tracker.errors++;
    end

    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/lts_pkg.sv
hw/rtl/lts_in_if.sv
hw/rtl/lts_out_if.sv
hw/rtl/lts_cell.sv
hw/rtl/lis_length_tails_stream.sv
tb/sv/tb_lis_length_tails_stream.sv
